[sv/stq_pkg.sv]
// shared types and constants for the sorted timer queue
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam logic [31:0] MS_PER_S    = 32'd1000;
  // ceil(2^38 / 1000): exact quotient by 1000 for every 32-bit dividend
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SCHED  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    EV_FIRED     = 3'd0,
    EV_SCHEDULED = 3'd1,
    EV_FULL      = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_NOT_FOUND = 3'd4
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND_POS,
    ST_SHIFT_UP,
    ST_WRITE,
    ST_FIND_ID,
    ST_SHIFT_DOWN,
    ST_HEAD_CHECK,
    ST_HEAD_READ,
    ST_DIV,
    ST_EMIT,
    ST_WAIT_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_item;     // capture the input transfer
    logic scan_clear;     // scan index to zero
    logic scan_inc;       // advance scan index
    logic shift_init;     // shift index to count (up) or scan index (down)
    logic shift_up_step;  // move entry shift-1 to shift, decrement
    logic shift_dn_step;  // move entry shift+1 to shift, increment
    logic write_new;      // write pending entry at scan index
    logic cnt_inc;
    logic cnt_dec;
    logic load_head;      // take head entry as pending reinsert
    logic div_start;
    logic div_step;
    logic set_rearm;      // pending entry = fired id, now + inc
    logic emit;           // load output register
    logic [2:0] emit_kind;
    logic emit_last;
    logic emit_head;      // output id from fired entry
    logic fire_inc;
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic full;
    logic empty;
    logic scan_end;       // scan index reached count
    logic scan_later;     // entry at scan is later than pending expiry
    logic scan_id_hit;
    logic shift_done;
    logic head_due;
    logic head_repeat;
    logic div_done;
    logic fire_limit;     // MAX_RESULTS reached
    logic fired_held;     // a popped timer waits to be reported
    logic out_busy;
  } stq_stat_t;

endpackage
`default_nettype wire

[sv/stq_if.sv]
// valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface stq_in_if #(parameter int ID_WIDTH = 32);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ID_WIDTH-1:0] timer_id;
  logic [31:0]         expire_second;
  logic [31:0]         repeat_ms;
  logic [31:0]         now_second;
  modport source (output valid, opcode, timer_id, expire_second, repeat_ms, now_second,
                  input ready);
  modport sink (input valid, opcode, timer_id, expire_second, repeat_ms, now_second,
                output ready);
endinterface

interface stq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_id;
  logic        last_event;
  modport source (output valid, event_kind, event_id, last_event, input ready);
  modport sink (input valid, event_kind, event_id, last_event, output ready);
endinterface
`default_nettype wire

[sv/stq_ctrl.sv]
// controller state machine of the timer queue
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire stq_pkg::stq_stat_t st,
  output stq_pkg::stq_cmd_t    cmd
);
  import stq_pkg::*;

  state_t state_r, state_nxt;
  logic   tick_r, tick_nxt;      // insertion belongs to a tick (rearm)
  logic   reject_r, reject_nxt;  // schedule hit a full table, or cancel missed
  logic   more;                  // another due timer may be popped

  assign more = !st.empty && st.head_due && !st.fire_limit;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tick_r   <= 1'b0;
      reject_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      reject_r <= reject_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    tick_nxt   = tick_r;
    reject_nxt = reject_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        tick_nxt   = 1'b0;
        reject_nxt = (st.op == OP_SCHED) ? st.full : 1'b1;
        case (st.op)
          OP_SCHED:  state_nxt = st.full ? ST_EMIT : ST_FIND_POS;
          OP_CANCEL: state_nxt = ST_FIND_ID;
          OP_TICK:   state_nxt = ST_HEAD_CHECK;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_FIND_POS: if (st.scan_end || st.scan_later) state_nxt = ST_SHIFT_UP;
      ST_SHIFT_UP: if (st.shift_done) state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = tick_r ? ST_HEAD_CHECK : ST_EMIT;
      ST_FIND_ID: begin
        if (st.scan_end) state_nxt = ST_EMIT;
        else if (st.scan_id_hit) begin
          state_nxt  = ST_SHIFT_DOWN;
          reject_nxt = 1'b0;
        end
      end
      ST_SHIFT_DOWN: if (st.shift_done) state_nxt = ST_EMIT;
      ST_HEAD_CHECK: begin
        if (!st.out_busy) state_nxt = more ? ST_HEAD_READ : ST_IDLE;
      end
      ST_HEAD_READ: begin
        tick_nxt  = 1'b1;
        state_nxt = st.head_repeat ? ST_DIV : ST_HEAD_CHECK;
      end
      ST_DIV: if (st.div_done) state_nxt = ST_FIND_POS;
      ST_EMIT: if (!st.out_busy) state_nxt = ST_WAIT_OUT;
      ST_WAIT_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.latch_item = in_valid;
        cmd.scan_clear = 1'b1;
      end
      ST_FIND_POS: begin
        if (st.scan_end || st.scan_later) cmd.shift_init = 1'b1;
        else cmd.scan_inc = 1'b1;
      end
      ST_SHIFT_UP: if (!st.shift_done) cmd.shift_up_step = 1'b1;
      ST_WRITE: begin
        cmd.write_new  = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      ST_FIND_ID: begin
        if (!st.scan_end && st.scan_id_hit) cmd.shift_init = 1'b1;
        else if (!st.scan_end) cmd.scan_inc = 1'b1;
      end
      ST_SHIFT_DOWN: begin
        if (st.shift_done) cmd.cnt_dec = 1'b1;
        else cmd.shift_dn_step = 1'b1;
      end
      ST_HEAD_CHECK: begin
        cmd.scan_clear = 1'b1;
        // report the timer popped last, marked last when nothing more follows
        if (!st.out_busy && st.fired_held) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EV_FIRED;
          cmd.emit_head = 1'b1;
          cmd.emit_last = !more;
        end
      end
      ST_HEAD_READ: begin
        // pop head: shift down from index 0 is done in one go by load_head
        cmd.load_head = 1'b1;
        cmd.cnt_dec   = 1'b1;
        cmd.fire_inc  = 1'b1;
        cmd.div_start = st.head_repeat;
      end
      ST_DIV: begin
        if (st.div_done) cmd.set_rearm = 1'b1;
        else cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          case (st.op)
            OP_SCHED:  cmd.emit_kind = reject_r ? EV_FULL : EV_SCHEDULED;
            OP_CANCEL: cmd.emit_kind = reject_r ? EV_NOT_FOUND : EV_CANCELLED;
            default:   cmd.emit_kind = EV_FIRED;
          endcase
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[sv/stq_datapath.sv]
// timer table, scan and shift indexes, divider and output register
`timescale 1ns / 1ps
`default_nettype none
module stq_datapath #(
  parameter int TIMERS   = 16,
  parameter int ID_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ID_WIDTH-1:0] in_timer_id,
  input  wire logic [31:0]        in_expire_second,
  input  wire logic [31:0]        in_repeat_ms,
  input  wire logic [31:0]        in_now_second,
  input  wire stq_pkg::stq_cmd_t  cmd,
  output stq_pkg::stq_stat_t      st,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_event_kind,
  output logic [31:0]             out_event_id,
  output logic                    out_last_event
);
  import stq_pkg::*;

  localparam int IW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);
  localparam int FW = $clog2(MAX_RESULTS + 1);

  // table rows held in registers: head pop and shifts touch neighbors
  logic [ID_WIDTH-1:0] ids_r [TIMERS];
  logic [31:0]         exp_r [TIMERS];
  logic [31:0]         rep_r [TIMERS];

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] scan_r;
  logic [CW-1:0] shift_r;
  logic [FW-1:0] fired_r;

  opcode_t             op_r;
  logic [ID_WIDTH-1:0] id_r;      // pending entry for insertion / cancel key
  logic [31:0]         pexp_r;
  logic [31:0]         prep_r;
  logic [31:0]         now_r;
  logic [ID_WIDTH-1:0] fid_r;

  // divide by 1000 as a registered multiply by the reciprocal
  logic [60:0] prod_r;
  logic        pdone_r;
  logic [22:0] quo;

  logic        ov_r;
  logic [2:0]  ok_r;
  logic [31:0] oid_r;
  logic        ol_r;

  logic [IW-1:0] scan_ix, shift_ix, shift_m1, shift_p1;
  logic [31:0]   diff_s, diff_h;
  logic [31:0]   inc;

  assign scan_ix  = scan_r[IW-1:0];
  assign shift_ix = shift_r[IW-1:0];
  assign shift_m1 = IW'(shift_r - CW'(1));
  assign shift_p1 = IW'(shift_r + CW'(1));
  assign diff_s   = exp_r[scan_ix] - pexp_r;
  assign diff_h   = exp_r[0] - now_r;
  assign quo      = prod_r[RECIP_SHIFT +: 23];
  assign inc      = (quo == 23'd0) ? 32'd1 : {9'd0, quo};

  // status
  always_comb begin
    st             = '0;
    st.op          = op_r;
    st.full        = (cnt_r == CW'(TIMERS));
    st.empty       = (cnt_r == '0);
    st.scan_end    = (scan_r >= cnt_r);
    st.scan_later  = (diff_s != 32'd0) && !diff_s[31];
    st.scan_id_hit = (ids_r[scan_ix] == id_r);
    st.shift_done  = (op_r == OP_CANCEL) ? (shift_r + CW'(1) >= cnt_r)
                                         : (shift_r == scan_r);
    st.head_due    = !((diff_h != 32'd0) && !diff_h[31]);
    st.head_repeat = (rep_r[0] != 32'd0);
    st.div_done    = pdone_r;
    st.fire_limit  = (fired_r == FW'(MAX_RESULTS));
    st.fired_held  = (fired_r != '0);
    st.out_busy    = ov_r && !out_ready;
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      scan_r  <= '0;
      shift_r <= '0;
      fired_r <= '0;
      ov_r    <= 1'b0;
      pdone_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_dec) cnt_r <= cnt_r - CW'(1);
      if (cmd.scan_clear) scan_r <= '0;
      else if (cmd.scan_inc) scan_r <= scan_r + CW'(1);
      if (cmd.shift_init) shift_r <= (op_r == OP_CANCEL) ? scan_r : cnt_r;
      else if (cmd.shift_up_step) shift_r <= shift_r - CW'(1);
      else if (cmd.shift_dn_step) shift_r <= shift_r + CW'(1);
      if (cmd.latch_item) fired_r <= '0;
      else if (cmd.fire_inc) fired_r <= fired_r + FW'(1);
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.div_start) pdone_r <= 1'b0;
      else if (cmd.div_step) pdone_r <= 1'b1;
    end
  end

  // item, pending entry and divider registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r   <= opcode_t'(in_opcode);
      id_r   <= in_timer_id;
      pexp_r <= in_expire_second;
      prep_r <= in_repeat_ms;
      now_r  <= in_now_second;
    end
    if (cmd.load_head) begin
      fid_r  <= ids_r[0];
      prep_r <= rep_r[0];
    end
    if (cmd.div_step) prod_r <= 61'(prep_r) * 61'(RECIP_1000);
    if (cmd.set_rearm) begin
      id_r   <= fid_r;
      pexp_r <= now_r + inc;
    end
  end

  // table moves: one row per cycle on shifts, whole pop on head read
  always_ff @(posedge clk) begin
    if (cmd.shift_up_step) begin
      ids_r[shift_ix] <= ids_r[shift_m1];
      exp_r[shift_ix] <= exp_r[shift_m1];
      rep_r[shift_ix] <= rep_r[shift_m1];
    end else if (cmd.shift_dn_step) begin
      ids_r[shift_ix] <= ids_r[shift_p1];
      exp_r[shift_ix] <= exp_r[shift_p1];
      rep_r[shift_ix] <= rep_r[shift_p1];
    end else if (cmd.write_new) begin
      ids_r[scan_ix] <= id_r;
      exp_r[scan_ix] <= pexp_r;
      rep_r[scan_ix] <= prep_r;
    end else if (cmd.load_head) begin
      for (int i = 0; i < TIMERS - 1; i++) begin
        ids_r[i] <= ids_r[i+1];
        exp_r[i] <= exp_r[i+1];
        rep_r[i] <= rep_r[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ok_r  <= cmd.emit_kind;
      oid_r <= 32'(cmd.emit_head ? fid_r : id_r);
      ol_r  <= cmd.emit_last;
    end
  end

  assign out_valid      = ov_r;
  assign out_event_kind = ok_r;
  assign out_event_id   = oid_r;
  assign out_last_event = ol_r;
endmodule
`default_nettype wire

[sv/sorted_timer_queue_unit.sv]
// top level of the sorted timer queue
`timescale 1ns / 1ps
`default_nettype none
// Sorted timer queue: holds up to TIMERS timers ordered by expiry second.
// One item is worked at a time and the input is ready only while idle.
// A schedule makes a position scan, then a one-row-a-cycle shift, before
// its write; a schedule into a full table skips both and goes straight to
// its result. A cancel scans for the id and shifts the rows behind it down.
// A tick pops and reports due timers, up to MAX_RESULTS; a repeating timer
// adds the reciprocal divide by 1000 and its reinsertion. A result held by
// a stalling receiver delays the item. The table rows hold no defined value until written.
module sorted_timer_queue_unit #(
  parameter int TIMERS   = 16,
  parameter int ID_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  stq_in_if.sink   in_ch,
  stq_out_if.source out_ch
);
  import stq_pkg::*;

  stq_cmd_t  cmd;
  stq_stat_t st;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  stq_datapath #(.TIMERS(TIMERS), .ID_WIDTH(ID_WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_ch.opcode),
    .in_timer_id      (in_ch.timer_id),
    .in_expire_second (in_ch.expire_second),
    .in_repeat_ms     (in_ch.repeat_ms),
    .in_now_second    (in_ch.now_second),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_event_kind   (out_ch.event_kind),
    .out_event_id     (out_ch.event_id),
    .out_last_event   (out_ch.last_event)
  );

`ifndef ASSERT_OFF
  // items are taken only while idle, never during an insertion
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !cmd.write_new)
    else $error("item taken during insertion");
  // count never passes the table size
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !st.full)
    else $error("insert into full table");
  // pop only when the table holds a timer
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !st.empty)
    else $error("remove from empty table");
`endif
endmodule
`default_nettype wire
